/* rtl/core/cobs_enc_pkg.sv */
package cobs_enc_pkg;

    localparam int MAX_BUFFER_DEF = 4096;

    localparam int CAP_W  = 13;
    localparam int ADDR_W = 12;
    localparam int LEN_W  = 13;
    localparam int POS_W  = 13;
    localparam int MAX_RESULTS = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;
    localparam logic [7:0]       CODE_MAX  = 8'hFF;
    localparam logic [7:0]       CODE_INIT = 8'h01;

    // APB register map: word index taken from paddr[2]
    localparam int PADDR_W = 3;
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAIL  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [LEN_W-1:0]  len;
    } result_t;

    typedef struct packed {
        logic [2:0]                      count;
        result_t [MAX_RESULTS-1:0]       res;
    } bundle_t;

    function automatic result_t mk_write(logic [ADDR_W-1:0] addr, logic [7:0] data);
        result_t r;
        r.kind = KIND_WRITE;
        r.addr = addr;
        r.data = data;
        r.len  = '0;
        return r;
    endfunction

    function automatic result_t mk_done(logic [LEN_W-1:0] len);
        result_t r;
        r.kind = KIND_DONE;
        r.addr = '0;
        r.data = '0;
        r.len  = len;
        return r;
    endfunction

    function automatic result_t mk_fail();
        result_t r;
        r.kind = KIND_FAIL;
        r.addr = '0;
        r.data = '0;
        r.len  = '0;
        return r;
    endfunction

endpackage

/* rtl/core/cobs_enc_cfg.sv */
module cobs_enc_cfg
    import cobs_enc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [CAP_W-1:0]   capacity
);

    logic [CAP_W-1:0] cap_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (wr_en)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata = {{(32-CAP_W){1'b0}}, cap_reg};
        end
    end

    assign capacity = cap_reg;

endmodule

/* rtl/core/cobs_enc_core.sv */
module cobs_enc_core
    import cobs_enc_pkg::*;
#(
    parameter int MAX_BUFFER = MAX_BUFFER_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       data_byte,
    input  logic             byte_present,
    input  logic             end_of_frame,
    input  logic [CAP_W-1:0] capacity,
    output logic             bun_valid,
    input  logic             bun_ready,
    output bundle_t          bun
);

    logic             in_vld_reg;
    logic [7:0]       byte_reg;
    logic             present_reg;
    logic             eof_reg;

    logic [POS_W-1:0] nwp_reg,  nwp_next;
    logic [POS_W-1:0] cpos_reg, cpos_next;
    logic [7:0]       code_reg, code_next;
    logic             fail_reg, fail_next;

    logic [CAP_W-1:0] cap;
    logic             fail_now;
    logic             adv;
    bundle_t          bun_c;

    // clamp the programmed capacity to the buffer size
    always_comb
    begin
        cap = capacity;
        if (32'(capacity) > MAX_BUFFER)
        begin
            cap = CAP_W'(MAX_BUFFER);
        end
    end

    always_comb
    begin
        nwp_next  = nwp_reg;
        cpos_next = cpos_reg;
        code_next = code_reg;
        fail_next = fail_reg;
        fail_now  = 1'b0;
        bun_c     = '0;

        if (present_reg && !fail_reg)
        begin
            if (byte_reg == 8'd0)
            begin
                if (cpos_next >= cap)
                begin
                    fail_now = 1'b1;
                end
                else
                begin
                    bun_c.res[bun_c.count[1:0]] = mk_write(cpos_next[ADDR_W-1:0], code_next);
                    bun_c.count = bun_c.count + 3'd1;
                    cpos_next   = nwp_next;
                    nwp_next    = nwp_next + POS_W'(1);
                    code_next   = CODE_INIT;
                end
            end
            else if (nwp_next >= cap)
            begin
                fail_now = 1'b1;
            end
            else
            begin
                bun_c.res[bun_c.count[1:0]] = mk_write(nwp_next[ADDR_W-1:0], byte_reg);
                bun_c.count = bun_c.count + 3'd1;
                nwp_next    = nwp_next + POS_W'(1);
                code_next   = code_next + 8'd1;
                // full block: store its code and open the next one
                if (code_next == CODE_MAX)
                begin
                    if (cpos_next >= cap)
                    begin
                        fail_now = 1'b1;
                    end
                    else
                    begin
                        bun_c.res[bun_c.count[1:0]] =
                            mk_write(cpos_next[ADDR_W-1:0], code_next);
                        bun_c.count = bun_c.count + 3'd1;
                        cpos_next   = nwp_next;
                        nwp_next    = nwp_next + POS_W'(1);
                        code_next   = CODE_INIT;
                    end
                end
            end
            if (fail_now)
            begin
                fail_next = 1'b1;
                bun_c.res[bun_c.count[1:0]] = mk_fail();
                bun_c.count = bun_c.count + 3'd1;
            end
        end

        if (eof_reg)
        begin
            if (!fail_next)
            begin
                if (cpos_next >= cap)
                begin
                    bun_c.res[bun_c.count[1:0]] = mk_fail();
                    bun_c.count = bun_c.count + 3'd1;
                end
                else
                begin
                    bun_c.res[bun_c.count[1:0]] = mk_write(cpos_next[ADDR_W-1:0], code_next);
                    bun_c.count = bun_c.count + 3'd1;
                    bun_c.res[bun_c.count[1:0]] = mk_done(nwp_next[LEN_W-1:0]);
                    bun_c.count = bun_c.count + 3'd1;
                end
            end
            nwp_next  = POS_W'(1);
            cpos_next = '0;
            code_next = CODE_INIT;
            fail_next = 1'b0;
        end
    end

    // items with no result retire without touching the output side
    assign adv       = in_vld_reg && (bun_ready || (bun_c.count == 3'd0));
    assign in_ready  = !in_vld_reg || adv;
    assign bun_valid = in_vld_reg && (bun_c.count != 3'd0);
    assign bun       = bun_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            nwp_reg    <= POS_W'(1);
            cpos_reg   <= '0;
            code_reg   <= CODE_INIT;
            fail_reg   <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                nwp_reg  <= nwp_next;
                cpos_reg <= cpos_next;
                code_reg <= code_next;
                fail_reg <= fail_next;
            end
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg    <= data_byte;
            present_reg <= byte_present;
            eof_reg     <= end_of_frame;
        end
    end

endmodule

/* rtl/core/cobs_enc_out.sv */
module cobs_enc_out
    import cobs_enc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              bun_valid,
    output logic              bun_ready,
    input  bundle_t           bun,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        kind,
    output logic [ADDR_W-1:0] write_address,
    output logic [7:0]        write_byte,
    output logic [LEN_W-1:0]  encoded_length,
    output logic              last_of_run
);

    bundle_t    bun_reg;
    logic       vld_reg;
    logic [1:0] idx_reg;
    result_t    cur;
    logic       last;
    logic       xfer;

    assign cur  = bun_reg.res[idx_reg];
    assign last = (({1'b0, idx_reg} + 3'd1) == bun_reg.count);
    assign xfer = vld_reg && out_ready;

    assign bun_ready = !vld_reg || (xfer && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (bun_ready)
        begin
            vld_reg <= bun_valid;
            idx_reg <= '0;
        end
        else if (xfer)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bun_ready && bun_valid)
        begin
            bun_reg <= bun;
        end
    end

    assign out_valid      = vld_reg;
    assign kind           = cur.kind;
    assign write_address  = cur.addr;
    assign write_byte     = cur.data;
    assign encoded_length = cur.len;
    assign last_of_run    = last;

endmodule

/* rtl/core/cobs_frame_encoder.sv */
// COBS frame encoder. Takes at most one raw byte per input transfer and
// reports every store into the encoded frame buffer as a (write_address,
// write_byte) result, followed at end of frame by a completion result
// carrying the encoded length, or by a single failure result when the frame
// does not fit in buffer_capacity bytes (the rest of a failed frame is
// dropped). One input transfer is accepted every cycle while the output side
// does not hold the input; the encoding of an item is done in one pass
// between the input register and the result bundle register, from which
// the results of the item are presented. An item yields zero to four
// results, and the output side delivers one result per cycle while
// out_ready is high, so the sustained input rate is set by the single output
// port: an item with results holds the input until its last result is taken.
// Program buffer_capacity (byte address 0) only while the encoder is idle.
module cobs_frame_encoder
    import cobs_enc_pkg::*;
#(
    parameter int MAX_BUFFER = MAX_BUFFER_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               byte_present,
    input  logic               end_of_frame,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic [ADDR_W-1:0]  write_address,
    output logic [7:0]         write_byte,
    output logic [LEN_W-1:0]   encoded_length,
    output logic               last_of_run
);

    logic [CAP_W-1:0] capacity;
    logic             bun_valid;
    logic             bun_ready;
    bundle_t          bun;

    cobs_enc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    cobs_enc_core #(
        .MAX_BUFFER (MAX_BUFFER)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .end_of_frame (end_of_frame),
        .capacity     (capacity),
        .bun_valid    (bun_valid),
        .bun_ready    (bun_ready),
        .bun          (bun)
    );

    cobs_enc_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .bun_valid      (bun_valid),
        .bun_ready      (bun_ready),
        .bun            (bun),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .write_address  (write_address),
        .write_byte     (write_byte),
        .encoded_length (encoded_length),
        .last_of_run    (last_of_run)
    );

endmodule

/* rtl/core/cobs_enc_checker.sv */
module cobs_enc_checker
    import cobs_enc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [1:0]        kind,
    input logic [ADDR_W-1:0] write_address,
    input logic [7:0]        write_byte,
    input logic [LEN_W-1:0]  encoded_length,
    input logic              last_of_run
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(write_address)
            && $stable(write_byte) && $stable(encoded_length) && $stable(last_of_run))
        else $error("stalled result changed");

    // completion and failure always close the run of an item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_DONE || kind == KIND_FAIL) |-> last_of_run)
        else $error("frame status is not last of run");

    // a completed frame holds at least its final code byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DONE |-> encoded_length != '0
            && write_address == '0 && write_byte == '0)
        else $error("bad completion result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_WRITE |-> encoded_length == '0 && write_byte != 8'd0)
        else $error("bad buffer write result");

endmodule

bind cobs_frame_encoder cobs_enc_checker u_chk (.*);

/* tb/sv/tb_cobs_frame_encoder.sv */
`timescale 1ns / 1ps

module tb_cobs_frame_encoder;
    import cobs_enc_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 6;

    typedef struct {
        kind_t             kind;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [LEN_W-1:0]  len;
        logic              last_flag;
    } enc_result_t;

    // Tracks the encoder state and the buffer stores it should report.
    class cobs_write_tracker;
        logic [CAP_W-1:0] capacity;
        logic [POS_W-1:0] write_pos;
        logic [POS_W-1:0] code_pos;
        logic [7:0]       code;
        bit               dropping;
        enc_result_t      expected_writes[$];
        int               errors;

        function new();
            capacity = CAP_RESET;
            errors   = 0;
            start_frame();
        endfunction

        function void start_frame();
            write_pos = 1;
            code_pos  = 0;
            code      = CODE_INIT;
            dropping  = 1'b0;
        endfunction

        function int limit();
            return (capacity > MAX_BUFFER_DEF) ? MAX_BUFFER_DEF : int'(capacity);
        endfunction

        function void push(kind_t k, logic [ADDR_W-1:0] a, logic [7:0] d,
                           logic [LEN_W-1:0] n);
            enc_result_t r;
            r.kind      = k;
            r.addr      = a;
            r.data      = d;
            r.len       = n;
            r.last_flag = 1'b0;
            expected_writes.push_back(r);
        endfunction

        // store the code of the open block, then open the next block
        function bit close_block();
            if (code_pos >= limit())
                return 1'b0;
            push(KIND_WRITE, code_pos[ADDR_W-1:0], code, '0);
            code_pos  = write_pos;
            write_pos = write_pos + 1'b1;
            code      = CODE_INIT;
            return 1'b1;
        endfunction

        function bit store_byte(logic [7:0] raw);
            if (raw == 8'h00)
                return close_block();
            if (write_pos >= limit())
                return 1'b0;
            push(KIND_WRITE, write_pos[ADDR_W-1:0], raw, '0);
            write_pos = write_pos + 1'b1;
            code      = code + 1'b1;
            if (code == CODE_MAX)
                return close_block();
            return 1'b1;
        endfunction

        function void note_item(logic [7:0] raw, logic present, logic eof);
            int queued;
            queued = expected_writes.size();
            if (present && !dropping)
            begin
                if (!store_byte(raw))
                begin
                    dropping = 1'b1;
                    push(KIND_FAIL, '0, '0, '0);
                end
            end
            if (eof)
            begin
                if (!dropping)
                begin
                    if (code_pos >= limit())
                        push(KIND_FAIL, '0, '0, '0);
                    else
                    begin
                        push(KIND_WRITE, code_pos[ADDR_W-1:0], code, '0);
                        push(KIND_DONE, '0, '0, write_pos[LEN_W-1:0]);
                    end
                end
                start_frame();
            end
            if (expected_writes.size() > queued)
                expected_writes[expected_writes.size() - 1].last_flag = 1'b1;
        endfunction

        function void complain(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch at %0t ns: %s", $time, msg);
        endfunction

        function void check_result(logic [1:0] k, logic [ADDR_W-1:0] a, logic [7:0] d,
                                   logic [LEN_W-1:0] n, logic lf);
            enc_result_t e;
            if (expected_writes.size() == 0)
            begin
                complain($sformatf("unexpected result kind=%0d addr=%0d byte=%02h len=%0d last=%0b",
                                   k, a, d, n, lf));
                return;
            end
            e = expected_writes.pop_front();
            if (k !== e.kind || a !== e.addr || d !== e.data || n !== e.len ||
                lf !== e.last_flag)
                complain($sformatf({"expected kind=%0d addr=%0d byte=%02h len=%0d last=%0b",
                                    ", got kind=%0d addr=%0d byte=%02h len=%0d last=%0b"},
                                   e.kind, e.addr, e.data, e.len, e.last_flag,
                                   k, a, d, n, lf));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         data_byte;
    logic               byte_present;
    logic               end_of_frame;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         kind;
    logic [ADDR_W-1:0]  write_address;
    logic [7:0]         write_byte;
    logic [LEN_W-1:0]   encoded_length;
    logic               last_of_run;

    cobs_write_tracker tracker = new();
    bit                steady;
    int                sent;
    int                quiet_cycles;

    cobs_frame_encoder u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_frame   (end_of_frame),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .write_address  (write_address),
        .write_byte     (write_byte),
        .encoded_length (encoded_length),
        .last_of_run    (last_of_run)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 10);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(kind, write_address, write_byte, encoded_length, last_of_run);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(logic [7:0] raw, logic present, logic eof);
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= raw;
        byte_present <= present;
        end_of_frame <= eof;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_item(raw, present, eof);
        if (present || eof)
            sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(int unsigned n_bytes, int unsigned zero_pct, bit long_run);
        logic [7:0] raw;
        bit         eof_inline;
        eof_inline = (n_bytes != 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < n_bytes; i++)
        begin
            // sprinkle empty transfers that the encoder must ignore
            if (!long_run && $urandom_range(0, 99) < 5)
                send_item(8'($urandom), 1'b0, 1'b0);
            if (long_run || $urandom_range(0, 99) >= zero_pct)
                raw = 8'($urandom_range(1, 255));
            else
                raw = 8'h00;
            send_item(raw, 1'b1, eof_inline && (i == n_bytes - 1));
        end
        if (!eof_inline)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        in_valid <= 1'b0;
        while (tracker.expected_writes.size() != 0)
            @(negedge clk);
        // let a result-free item still in flight drain
        repeat (DRAIN_CYCLES) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.capacity = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[CAP_W-1:0] !== value)
            tracker.complain($sformatf("capacity read back %0d, expected %0d",
                                       prdata[CAP_W-1:0], value));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        logic [CAP_W-1:0] cap;
        int unsigned      long_len;
        int               quota;

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        data_byte    = '0;
        byte_present = 1'b0;
        end_of_frame = 1'b0;
        out_ready    = 1'b0;
        steady       = 1'b0;
        sent         = 0;
        quiet_cycles = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset capacity: empty frame, ignored item, mixed bytes, lone zero
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h3C, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);

        // no room at all: every frame fails, bytes after the failure are dropped
        write_capacity(13'd0);
        send_item(8'h11, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h5A, 1'b0, 1'b1);

        // room for the code byte only
        write_capacity(13'd1);
        send_item(8'h05, 1'b1, 1'b0);
        send_item(8'hFE, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);

        // above the buffer size: clamps to the buffer
        write_capacity(13'h1FFF);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'hFE, 1'b1, 1'b1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       cap = CAP_RESET;
                1:       cap = 13'd2;
                2:       cap = 13'd255;
                3:       cap = 13'd0;
                4:       cap = 13'h1FFF;
                5:       cap = 13'd256;
                6:       cap = 13'd1;
                7:       cap = 13'd4097;
                8:       cap = 13'($urandom_range(3, 40));
                9:       cap = 13'($urandom_range(1, 4096));
                default: cap = 13'($urandom_range(1, 64));
            endcase
            write_capacity(cap);
            steady = (phase == 0);
            // full blocks: 254 data bytes force a 0xFF code
            if (phase == 0)
                long_len = 254 + $urandom_range(0, 12);
            else
                long_len = 0;
            if (long_len != 0)
                send_frame(long_len, 0, 1'b1);
            quota = sent + PHASE_ITEMS;
            while (sent < quota)
                send_frame($urandom_range(0, 12), $urandom_range(0, 50), 1'b0);
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        while (tracker.expected_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.expected_writes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/cobs_enc_pkg.sv
rtl/core/cobs_enc_cfg.sv
rtl/core/cobs_enc_core.sv
rtl/core/cobs_enc_out.sv
rtl/core/cobs_frame_encoder.sv
rtl/core/cobs_enc_checker.sv
tb/sv/tb_cobs_frame_encoder.sv
